FILE: src/gb8_pkg.sv
// ----------------------------------------------------------------------------
// gb8_pkg
// Types and fixed constants shared by the 8x8 glyph blitter.
// ----------------------------------------------------------------------------
package gb8_pkg;

  localparam int GLYPH_SIZE = 8;
  localparam int ROW_W      = 3;
  localparam int GLYPH_BITS = GLYPH_SIZE * 8;
  localparam int CODE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int STRIDE_W   = 13;
  localparam int OFF_W      = 25;
  localparam int COLOUR_W   = 32;
  localparam int FCNT_W     = 4;

  localparam logic              OP_LOAD      = 1'b0;
  localparam logic              OP_DRAW      = 1'b1;
  localparam logic [CODE_W-1:0] MAX_CODE     = 8'd127;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1920;
  localparam logic [FCNT_W-1:0] FETCH_LAST   = 4'(GLYPH_SIZE);
  localparam logic [ROW_W-1:0]  COL_LAST     = 3'(GLYPH_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_NEXT_ROW
  } state_t;

endpackage

FILE: src/glyph_blitter_8x8.sv
// ----------------------------------------------------------------------------
// glyph_blitter_8x8
// 8x8 bitmap font blitter: loads glyph rows, turns draw beats into pixel writes.
// ----------------------------------------------------------------------------
// A load beat (opcode 0) writes one glyph row into the font RAM. A draw beat
// (opcode 1) first reads the glyph's 8 rows from the font RAM (one read
// port, registered data), then scans the glyph one pixel per cycle, while
// the output is not stalled, through a single shared 25-bit adder that also
// steps the row base by line_stride; an all-zero row is skipped whole and
// the scan ends as soon as no set pixel is left. A draw holds in_stall high
// until its scan ends, and longer while the output is stalled.
// Codes above 127 or at or above GLYPH_COUNT draw nothing. Only draw glyphs
// that have been loaded: unloaded rows read back as garbage.
// ----------------------------------------------------------------------------
module glyph_blitter_8x8
  import gb8_pkg::*;
#(
  parameter int GLYPH_COUNT = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [CODE_W-1:0]   glyph_code,
  input  logic [ROW_W-1:0]    font_row,
  input  logic [7:0]          row_bits,
  input  logic [COORD_W-1:0]  pos_x,
  input  logic [COORD_W-1:0]  pos_y,
  input  logic [COLOUR_W-1:0] colour,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OFF_W-1:0]    pixel_offset,
  output logic [COLOUR_W-1:0] pixel_colour,
  output logic                last_pixel
);

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state, state_next;

  logic [STRIDE_W-1:0]   line_stride;
  logic [CODE_W-1:0]     code_q;
  logic [COORD_W-1:0]    px_q;
  logic [COLOUR_W-1:0]   colour_q;
  logic [OFF_W-1:0]      product;
  logic [OFF_W-1:0]      row_base, row_base_next;
  logic [GLYPH_BITS-1:0] bits, bits_next;
  logic [ROW_W-1:0]      col, col_next;
  logic [FCNT_W-1:0]     fetch_cnt, fetch_cnt_next;

  logic              accept, code_ok, draw_start, can_emit, emit;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic [OFF_W-1:0]  add_a, add_b, sum;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign code_ok    = ({1'b0, glyph_code} < 9'(GLYPH_COUNT));
  assign draw_start = accept && (opcode == OP_DRAW) && (glyph_code <= MAX_CODE) && code_ok;
  assign ram_we     = accept && (opcode == OP_LOAD) && code_ok;
  assign ram_waddr  = ADDR_W'({glyph_code, font_row});
  assign ram_raddr  = ADDR_W'({code_q, fetch_cnt[ROW_W-1:0]});
  assign can_emit   = !out_valid || !out_stall;

  gb8_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_font (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(row_bits),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared adder: row base setup, pixel offset, row advance
  assign sum = add_a + add_b;

  always_comb begin
    state_next     = state;
    emit           = 1'b0;
    add_a          = row_base;
    add_b          = '0;
    row_base_next  = row_base;
    bits_next      = bits;
    col_next       = col;
    fetch_cnt_next = fetch_cnt;
    case (state)
      ST_IDLE: begin
        if (draw_start) begin
          state_next     = ST_FETCH;
          fetch_cnt_next = '0;
        end
      end
      ST_FETCH: begin
        fetch_cnt_next = fetch_cnt + 1'b1;
        if (fetch_cnt == '0) begin
          add_a         = product;
          add_b         = OFF_W'(px_q);
          row_base_next = sum;
        end else begin
          // rows arrive top first; row 0 ends up in the top byte
          bits_next = {bits[GLYPH_BITS-9:0], ram_rdata};
        end
        if (fetch_cnt == FETCH_LAST) begin
          state_next = ST_SCAN;
          col_next   = '0;
        end
      end
      ST_SCAN: begin
        if (bits == '0) begin
          state_next = ST_IDLE;
        end else if (col == '0 && bits[GLYPH_BITS-1 -: 8] == 8'd0) begin
          // skip a whole empty row without stepping through its pixels
          bits_next     = bits << 8;
          add_b         = OFF_W'(line_stride);
          row_base_next = sum;
        end else if (bits[GLYPH_BITS-1] && !can_emit) begin
          state_next = ST_SCAN;
        end else begin
          emit      = bits[GLYPH_BITS-1];
          add_b     = OFF_W'(col);
          bits_next = bits << 1;
          col_next  = col + 1'b1;
          if (col == COL_LAST) begin
            state_next = ST_NEXT_ROW;
          end
        end
      end
      ST_NEXT_ROW: begin
        add_b         = OFF_W'(line_stride);
        row_base_next = sum;
        state_next    = ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      line_stride <= STRIDE_RESET;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        line_stride <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_base  <= row_base_next;
    bits      <= bits_next;
    col       <= col_next;
    fetch_cnt <= fetch_cnt_next;
    if (draw_start) begin
      code_q   <= glyph_code;
      px_q     <= pos_x;
      colour_q <= colour;
      product  <= OFF_W'(pos_y) * OFF_W'(line_stride);
    end
    if (emit) begin
      pixel_offset <= sum;
      pixel_colour <= colour_q;
      last_pixel   <= ~|bits[GLYPH_BITS-2:0];
    end
  end

  // a new pixel never overwrites a beat that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("pixel emitted over a stalled beat");

  // the last pixel of a glyph leaves nothing to scan
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (emit && bits[GLYPH_BITS-2:0] == '0) |=> (bits == '0))
    else $error("set pixels remain after last pixel");

  // font RAM is written only by a beat taken while idle
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("font write outside idle");

  // glyph fetch never runs past its final row
  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (fetch_cnt <= FETCH_LAST))
    else $error("glyph fetch overran");

endmodule

FILE: src/gb8_ram.sv
// ----------------------------------------------------------------------------
// gb8_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gb8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: 8x8 glyph blitter
// Loads glyphs into the font store and draws them under several line strides.
// A scoreboard class keeps its own copy of the font and the stride, works out
// every framebuffer write that a draw beat should produce, and checks the
// pixel writes in order. Sender and receiver idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
  import gb8_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 8;
  localparam int GLYPH_COUNT      = 128;
  localparam int DRAIN_CYCLES     = 100;
  localparam int IDLE_LIMIT       = 5000;
  localparam int REPORT_LIMIT     = 10;
  localparam int STRIDE_PHASES    = 6;
  localparam int RANDOM_PER_PHASE = 38;

  typedef struct packed {
    logic                opcode;
    logic [CODE_W-1:0]   glyph_code;
    logic [ROW_W-1:0]    font_row;
    logic [7:0]          row_bits;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COLOUR_W-1:0] colour;
  } blit_beat_t;

  typedef struct packed {
    logic [OFF_W-1:0]    offset;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_write_t;

  class pixel_scoreboard;
    pixel_write_t        pending_writes[$];
    bit [7:0]            glyph_rows[GLYPH_COUNT*GLYPH_SIZE];
    bit [STRIDE_W-1:0]   line_stride;
    int unsigned         mismatches;
    int unsigned         loads_seen;
    int unsigned         draws_seen;
    int unsigned         writes_checked;

    function new();
      line_stride    = STRIDE_RESET;
      mismatches     = 0;
      loads_seen     = 0;
      draws_seen     = 0;
      writes_checked = 0;
      foreach (glyph_rows[i]) glyph_rows[i] = 8'h00;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("MISMATCH %0t: %s", $realtime, msg);
    endfunction

    // Record an accepted beat: a load updates the font copy, a draw expands into its pixel writes.
    function void note_beat(blit_beat_t b);
      int           base;
      int           total;
      int           k;
      bit [31:0]    full;
      pixel_write_t w;
      base  = int'(b.glyph_code) * GLYPH_SIZE;
      total = 0;
      k     = 0;
      if (b.opcode == OP_LOAD) begin
        loads_seen++;
        if (b.glyph_code < GLYPH_COUNT) glyph_rows[base + int'(b.font_row)] = b.row_bits;
        return;
      end
      draws_seen++;
      if (b.glyph_code > MAX_CODE || b.glyph_code >= GLYPH_COUNT) return;
      for (int r = 0; r < GLYPH_SIZE; r++) total += $countones(glyph_rows[base + r]);
      for (int r = 0; r < GLYPH_SIZE; r++) begin
        for (int c = 0; c < 8; c++) begin
          if (glyph_rows[base + r][7 - c]) begin
            k++;
            full     = (32'(b.pos_y) + 32'(r)) * 32'(line_stride) + 32'(b.pos_x) + 32'(c);
            w.offset = full[OFF_W-1:0];
            w.colour = b.colour;
            w.last   = (k == total);
            pending_writes.push_back(w);
          end
        end
      end
    endfunction

    function void check_write(logic [OFF_W-1:0] offset, logic [COLOUR_W-1:0] colour,
                              logic last);
      pixel_write_t want;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write offset=%0h colour=%0h last=%0b",
                                  offset, colour, last));
        return;
      end
      want = pending_writes.pop_front();
      if (want.offset !== offset || want.colour !== colour || want.last !== last)
        report_mismatch($sformatf(
          "expected offset=%0h colour=%0h last=%0b, got offset=%0h colour=%0h last=%0b",
          want.offset, want.colour, want.last, offset, colour, last));
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_wen      = 1'b0;
  logic [STRIDE_W-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                opcode       = OP_LOAD;
  logic [CODE_W-1:0]   glyph_code   = '0;
  logic [ROW_W-1:0]    font_row     = '0;
  logic [7:0]          row_bits     = '0;
  logic [COORD_W-1:0]  pos_x        = '0;
  logic [COORD_W-1:0]  pos_y        = '0;
  logic [COLOUR_W-1:0] colour       = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [OFF_W-1:0]    pixel_offset;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_pixel;

  pixel_scoreboard glyph_sb;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              quiet_cycles   = 0;
  int              strides_used   = 0;
  bit [7:0]        rows_loaded[GLYPH_COUNT];
  int              ready_codes[$];

  glyph_blitter_8x8 #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .glyph_code  (glyph_code),
    .font_row    (font_row),
    .row_bits    (row_bits),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .colour      (colour),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_offset(pixel_offset),
    .pixel_colour(pixel_colour),
    .last_pixel  (last_pixel)
  );

  always begin
    #(CLK_PERIOD/2) clk = 1'b1;
    #(CLK_PERIOD/2) clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      glyph_sb.check_write(pixel_offset, pixel_colour, last_pixel);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(input blit_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= b.opcode;
    glyph_code <= b.glyph_code;
    font_row   <= b.font_row;
    row_bits   <= b.row_bits;
    pos_x      <= b.pos_x;
    pos_y      <= b.pos_y;
    colour     <= b.colour;
    do @(posedge clk); while (in_stall);
    glyph_sb.note_beat(b);
    if (b.opcode == OP_LOAD && b.glyph_code < GLYPH_COUNT && rows_loaded[b.glyph_code] != 8'hFF)
    begin
      rows_loaded[b.glyph_code][b.font_row] = 1'b1;
      if (rows_loaded[b.glyph_code] == 8'hFF) ready_codes.push_back(int'(b.glyph_code));
    end
  endtask

  task automatic load_row(input int code, input int row, input logic [7:0] bits);
    blit_beat_t b;
    b.opcode     = OP_LOAD;
    b.glyph_code = CODE_W'(code);
    b.font_row   = ROW_W'(row);
    b.row_bits   = bits;
    b.pos_x      = COORD_W'($urandom_range(4095));
    b.pos_y      = COORD_W'($urandom_range(4095));
    b.colour     = $urandom;
    send_beat(b);
  endtask

  task automatic draw_glyph(input int code, input int x, input int y,
                            input logic [COLOUR_W-1:0] c);
    blit_beat_t b;
    b.opcode     = OP_DRAW;
    b.glyph_code = CODE_W'(code);
    b.font_row   = ROW_W'($urandom_range(7));
    b.row_bits   = 8'($urandom_range(255));
    b.pos_x      = COORD_W'(x);
    b.pos_y      = COORD_W'(y);
    b.colour     = c;
    send_beat(b);
  endtask

  // Load all eight rows; some glyphs come out blank on purpose.
  task automatic load_glyph(input int code);
    bit   blank;
    int   pick;
    logic [7:0] bits;
    blank = ($urandom_range(9) == 0);
    for (int r = 0; r < GLYPH_SIZE; r++) begin
      pick = $urandom_range(99);
      if (blank || pick < 15) bits = 8'h00;
      else if (pick < 30)     bits = 8'hFF;
      else                    bits = 8'($urandom_range(255));
      load_row(code, r, bits);
    end
  endtask

  function automatic int pick_coord();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 4095 : 0;
    return $urandom_range(4095);
  endfunction

  // Wait until every pixel write is back and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (glyph_sb.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_stride(input logic [STRIDE_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    glyph_sb.line_stride = value;
    strides_used++;
  endtask

  task automatic run_directed();
    for (int r = 0; r < GLYPH_SIZE; r++) load_row(int'(MAX_CODE), r, 8'hFF);
    draw_glyph(int'(MAX_CODE), 0, 0, 32'h0000_0000);
    draw_glyph(int'(MAX_CODE), 4095, 4095, 32'hFFFF_FFFF);
    // sparse glyph: leftmost pixel on top, rightmost at the bottom
    for (int r = 0; r < GLYPH_SIZE; r++)
      load_row(0, r, (r == 0) ? 8'h80 : (r == 7) ? 8'h01 : (r == 3) ? 8'h5A : 8'h00);
    draw_glyph(0, 4095, 0, 32'hA5A5_5A5A);
    // codes past the font are dropped on load and on draw
    load_row(200, 3, 8'hFF);
    load_row(255, 7, 8'hFF);
    draw_glyph(128, 100, 100, 32'h1234_5678);
    draw_glyph(255, 4095, 4095, 32'h8765_4321);
    // blank glyph: no write and no last marker
    load_row(0, 0, 8'h00);
    load_row(0, 3, 8'h00);
    load_row(0, 7, 8'h00);
    draw_glyph(0, 17, 33, 32'hDEAD_BEEF);
  endtask

  task automatic random_traffic(input int target);
    int done;
    int pick;
    int code;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(99);
      if (pick < 22 || ready_codes.size() == 0) begin
        load_glyph($urandom_range(GLYPH_COUNT - 1));
        done += GLYPH_SIZE;
      end else if (pick < 28) begin
        code = $urandom_range(255);
        load_row(code, $urandom_range(7), 8'($urandom_range(255)));
        if (code < GLYPH_COUNT) done++;
      end else if (pick < 34) begin
        draw_glyph($urandom_range(255, 128), pick_coord(), pick_coord(), $urandom);
      end else begin
        code = ready_codes[$urandom_range(ready_codes.size() - 1)];
        draw_glyph(code, pick_coord(), pick_coord(), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    logic [STRIDE_W-1:0] stride_plan[STRIDE_PHASES];
    glyph_sb = new();
    foreach (rows_loaded[i]) rows_loaded[i] = 8'h00;
    stride_plan[0] = 13'd1;
    stride_plan[1] = 13'd4096;
    stride_plan[2] = 13'd0;
    stride_plan[3] = 13'd8191;
    stride_plan[4] = STRIDE_W'($urandom_range(4096, 1));
    stride_plan[5] = STRIDE_W'($urandom_range(8191));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idle_mode(0);
    run_directed();
    for (int p = 0; p < STRIDE_PHASES; p++) begin
      drain();
      program_stride(stride_plan[p]);
      set_idle_mode((p + 1) % 4);
      random_traffic(RANDOM_PER_PHASE);
    end
    drain();
    if (glyph_sb.pending_writes.size() != 0)
      $display("%0d expected pixel writes never arrived", glyph_sb.pending_writes.size());
    $display("Run covered %0d load beats and %0d draw beats, %0d pixel writes checked,",
             glyph_sb.loads_seen, glyph_sb.draws_seen, glyph_sb.writes_checked);
    $display("over %0d stride settings beyond the reset value, %0d mismatches.",
             strides_used, glyph_sb.mismatches);
    if (glyph_sb.mismatches == 0 && glyph_sb.pending_writes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
